[src/bmbc_pkg.sv]
// ----------------------------------------------------------------------------
// bmbc_pkg: shared types and constants for the banked memory bus controller
// Beat payloads, access mode codes, address region codes and the request
// bundle that the sequencer sends to the store.
// ----------------------------------------------------------------------------
`default_nettype none

package bmbc_pkg;

	// Size of one switchable ROM bank
	localparam int unsigned BANK_BYTES = 16384;
	localparam int unsigned BANK_OFF_W = 14;

	// Access mode codes carried in the input beat
	localparam logic [2:0] MODE_RD_BYTE  = 3'd0;
	localparam logic [2:0] MODE_RD_SBYTE = 3'd1;
	localparam logic [2:0] MODE_WR_BYTE  = 3'd2;
	localparam logic [2:0] MODE_RD_WORD  = 3'd3;
	localparam logic [2:0] MODE_WR_WORD  = 3'd4;
	localparam logic [2:0] MODE_LD_MAIN  = 3'd5;
	localparam logic [2:0] MODE_LD_ROM   = 3'd6;

	// Write regions, decoded from address bits [15:13]
	localparam logic [2:0] REGION_RAM_EN = 3'b000;
	localparam logic [2:0] REGION_BANK   = 3'b001;
	localparam logic [2:0] REGION_RO     = 3'b010;
	localparam logic [2:0] REGION_MODE   = 3'b011;

	// Read window of the switchable ROM bank, address bits [15:14]
	localparam logic [1:0] ROM_WINDOW = 2'b01;

	// Value that turns the RAM enable on
	localparam logic [7:0] RAM_EN_KEY = 8'h0A;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] address;
		logic [15:0] write_data;
		logic [19:0] rom_index;
	} in_item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        error;
		logic        ram_enabled;
		logic [7:0]  banking_mode;
		logic [7:0]  current_rom_bank;
	} out_item_t;

	// One byte access to the stores
	typedef struct packed {
		logic        main_re;
		logic        main_we;
		logic [15:0] main_addr;
		logic        rom_re;
		logic        rom_we;
		logic [7:0]  bank_num;
		logic [13:0] rom_off;
		logic [7:0]  wdata;
	} mem_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HIGH,
		ST_DONE
	} seq_state_t;

endpackage

`default_nettype wire

[src/banked_memory_bus_controller.sv]
// ----------------------------------------------------------------------------
// banked_memory_bus_controller: 16-bit bus with switchable ROM banks
// Byte and word reads and writes over a 64 KB main store and a banked ROM
// store, with address-decoded control latches and store load modes.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------
//  input   | in        | in_valid / in_ready   | in_item   (in_item_t)
//  output  | out       | out_valid / out_ready | out_item  (out_item_t)
//
//  Byte, load and unused-mode beats pass through ST_IDLE and ST_DONE, word
//  beats through ST_HIGH as well: one step per byte access, plus one to shape the result.
//  A new beat is taken while the previous result waits in the output
//  register; the sequencer holds at its last step while that register is full.
//  Reset sets the ROM bank to 1 and clears RAM enable and mode; the stores
//  are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module banked_memory_bus_controller
	import bmbc_pkg::*;
#(
	parameter int unsigned ROM_BANKS = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	mem_req_t   req;
	logic [7:0] rdata;

	// Sequencer and latches
	bmbc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.req       (req),
		.rdata     (rdata)
	);

	// Byte stores
	bmbc_store #(
		.ROM_BANKS (ROM_BANKS)
	) u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

endmodule

`default_nettype wire

[src/bmbc_store.sv]
// ----------------------------------------------------------------------------
// bmbc_store: main and ROM byte stores
// Two single-port synchronous memories with registered read data. The ROM
// bank number is reduced modulo the bank count through a constant table.
// ----------------------------------------------------------------------------
`default_nettype none

module bmbc_store
	import bmbc_pkg::*;
#(
	parameter int unsigned ROM_BANKS = 64
) (
	input  wire logic     clk,
	input  wire mem_req_t req,
	output logic [7:0]    rdata
);

	localparam int unsigned ROM_DEPTH = ROM_BANKS * BANK_BYTES;
	localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);
	localparam int unsigned BANK_W    = ROM_AW - BANK_OFF_W;

	logic [7:0] main_mem [65536];
	logic [7:0] rom_mem [ROM_DEPTH];

	logic [BANK_W-1:0] bank_mod [256];
	logic [ROM_AW-1:0] rom_addr;
	logic [7:0]        main_rd_q;
	logic [7:0]        rom_rd_q;
	logic              rom_sel_q;

	// Bank number modulo the bank count, worked out at elaboration
	for (genvar i = 0; i < 256; i++) begin : g_bank_mod
		assign bank_mod[i] = BANK_W'(i % ROM_BANKS);
	end

	assign rom_addr = {bank_mod[req.bank_num], req.rom_off};

	// Main store port
	always_ff @(posedge clk) begin
		if (req.main_we) begin
			main_mem[req.main_addr] <= req.wdata;
		end
		if (req.main_re) begin
			main_rd_q <= main_mem[req.main_addr];
		end
	end

	// ROM store port
	always_ff @(posedge clk) begin
		if (req.rom_we) begin
			rom_mem[rom_addr] <= req.wdata;
		end
		if (req.rom_re) begin
			rom_rd_q <= rom_mem[rom_addr];
		end
	end

	// Remember which store the last read went to
	always_ff @(posedge clk) begin
		if (req.main_re || req.rom_re) begin
			rom_sel_q <= req.rom_re;
		end
	end

	assign rdata = rom_sel_q ? rom_rd_q : main_rd_q;

endmodule

`default_nettype wire

[src/bmbc_seq.sv]
// ----------------------------------------------------------------------------
// bmbc_seq: access sequencer
// Splits each beat into byte accesses, decodes writes into the control
// latches or the main store, gathers read bytes and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bmbc_seq
	import bmbc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item,
	output mem_req_t       req,
	input  wire logic [7:0] rdata
);

	seq_state_t state_q, state_d;

	in_item_t  item_q;
	logic [7:0] lo_q;
	logic       err_q;
	logic [7:0] bank_q;
	logic       ram_en_q;
	logic [7:0] mode_q;
	out_item_t  out_q;
	logic       out_valid_q;

	logic        acc_go;
	logic [2:0]  acc_mode;
	logic [15:0] acc_addr;
	logic [7:0]  acc_byte;
	logic        rd_op;
	logic        wr_op;
	logic        wr_err;
	logic        is_word;
	logic        out_free;
	logic        finish;
	logic [15:0] rd_result;

	// Select the byte access of this cycle: low byte from the port, high byte from the item
	always_comb begin
		acc_mode = in_item.mode;
		acc_addr = in_item.address;
		acc_byte = in_item.write_data[7:0];
		acc_go   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				acc_go = in_valid;
			end
			ST_HIGH: begin
				acc_mode = item_q.mode;
				acc_addr = item_q.address + 16'd1;
				acc_byte = item_q.write_data[15:8];
				acc_go   = 1'b1;
			end
			ST_DONE: begin
				acc_go = 1'b0;
			end
			default: begin
				acc_go = 1'b0;
			end
		endcase
	end

	assign rd_op = (acc_mode == MODE_RD_BYTE) || (acc_mode == MODE_RD_SBYTE)
		|| (acc_mode == MODE_RD_WORD);
	assign wr_op = (acc_mode == MODE_WR_BYTE) || (acc_mode == MODE_WR_WORD);
	assign wr_err = acc_go && wr_op && (acc_addr[15:13] == REGION_RO);
	assign is_word = (in_item.mode == MODE_RD_WORD) || (in_item.mode == MODE_WR_WORD);

	// Build the store request
	always_comb begin
		req           = '0;
		req.main_addr = acc_addr;
		req.bank_num  = bank_q;
		req.rom_off   = acc_addr[13:0];
		req.wdata     = acc_byte;
		if (acc_go) begin
			if (rd_op) begin
				if (acc_addr[15:14] == ROM_WINDOW) begin
					req.rom_re = 1'b1;
				end else begin
					req.main_re = 1'b1;
				end
			end
			if (wr_op && acc_addr[15]) begin
				req.main_we = 1'b1;
			end
			if (acc_mode == MODE_LD_MAIN) begin
				req.main_we = 1'b1;
			end
			if (acc_mode == MODE_LD_ROM) begin
				req.rom_we   = 1'b1;
				req.bank_num = {2'b00, in_item.rom_index[19:14]};
				req.rom_off  = in_item.rom_index[13:0];
			end
		end
	end

	// Update the control latches on writes below the main store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= 8'd1;
			ram_en_q <= 1'b0;
			mode_q   <= 8'd0;
		end else if (acc_go && wr_op && !acc_addr[15]) begin
			unique case (acc_addr[15:13])
				REGION_RAM_EN: ram_en_q <= (acc_byte == RAM_EN_KEY);
				REGION_BANK:   bank_q   <= (acc_byte == 8'd0) ? 8'd1 : acc_byte;
				REGION_MODE:   mode_q   <= acc_byte;
				REGION_RO:     mode_q   <= mode_q;
				default:       mode_q   <= mode_q;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = is_word ? ST_HIGH : ST_DONE;
				end
			end
			ST_HIGH: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_free = !out_valid_q || out_ready;
		finish   = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the item, the low read byte and the error flag
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_item;
			err_q  <= wr_err;
		end
		if (state_q == ST_HIGH) begin
			lo_q  <= rdata;
			err_q <= err_q | wr_err;
		end
	end

	// Shape the read result
	always_comb begin
		unique case (item_q.mode)
			MODE_RD_BYTE:  rd_result = {8'h00, rdata};
			MODE_RD_SBYTE: rd_result = {{8{rdata[7]}}, rdata};
			MODE_RD_WORD:  rd_result = {rdata, lo_q};
			default:       rd_result = 16'h0000;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.read_data        <= rd_result;
			out_q.error            <= err_q;
			out_q.ram_enabled      <= ram_en_q;
			out_q.banking_mode     <= mode_q;
			out_q.current_rom_bank <= bank_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

[verif/tb_banked_memory_bus_controller.sv]
// ----------------------------------------------------------------------------
// tb_banked_memory_bus_controller: self-checking bench for the banked bus
// Drives byte, word and load beats through the valid/ready input channel,
// predicts every result beat from a private copy of the stores and latches,
// and compares each result field by field under random stalls on both sides.
// ----------------------------------------------------------------------------

module tb_banked_memory_bus_controller;
	timeunit 1ns;
	timeprecision 1ps;

	import bmbc_pkg::*;

	localparam int unsigned ROM_BANKS   = 64;
	localparam int          ROM_SIZE    = ROM_BANKS * BANK_BYTES;
	localparam logic [2:0]  MODE_UNUSED = 3'd7;
	localparam int          N_RANDOM    = 1000;
	localparam int          QUIET_TAIL  = 150;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// Predicts bus results and holds the results still owed by the block
	class bank_bus_model;
		logic [7:0]  main_mem [int];
		logic [7:0]  rom_mem [int];
		int          main_addrs[$];
		int          rom_slots[$];
		logic [7:0]  bank_sel;
		logic        ram_en;
		logic [7:0]  mode_reg;
		out_item_t   due_results[$];
		int          errors;
		int          beats_in;
		int          results_seen;
		int          ro_hits;
		int          mode_hits[8];

		function new();
			bank_sel = 8'd1;
			ram_en = 1'b0;
			mode_reg = 8'd0;
			errors = 0;
			beats_in = 0;
			results_seen = 0;
			ro_hits = 0;
			foreach (mode_hits[i]) mode_hits[i] = 0;
		endfunction

		function int bank_base();
			return (int'(bank_sel) * int'(BANK_BYTES)) % ROM_SIZE;
		endfunction

		function int rom_slot(logic [15:0] a);
			return (int'(bank_sel) * int'(BANK_BYTES) + int'(a[13:0])) % ROM_SIZE;
		endfunction

		function bit can_read(logic [15:0] a);
			if (a[15:14] == ROM_WINDOW) begin
				return rom_mem.exists(rom_slot(a));
			end
			return main_mem.exists(int'(a));
		endfunction

		function logic [7:0] bus_byte(logic [15:0] a);
			if (a[15:14] == ROM_WINDOW) begin
				return rom_mem[rom_slot(a)];
			end
			return main_mem[int'(a)];
		endfunction

		function void store_main(logic [15:0] a, logic [7:0] v);
			if (!main_mem.exists(int'(a))) main_addrs.push_back(int'(a));
			main_mem[int'(a)] = v;
		endfunction

		function void store_rom(int slot, logic [7:0] v);
			if (!rom_mem.exists(slot)) rom_slots.push_back(slot);
			rom_mem[slot] = v;
		endfunction

		// Decode one bus write; return 1 when it lands in read-only space
		function bit bus_write(logic [15:0] a, logic [7:0] v);
			case (a[15:13])
				REGION_RAM_EN: ram_en = (v == RAM_EN_KEY);
				REGION_BANK:   bank_sel = (v == 8'd0) ? 8'd1 : v;
				REGION_RO:     return 1'b1;
				REGION_MODE:   mode_reg = v;
				default:       store_main(a, v);
			endcase
			return 1'b0;
		endfunction

		// Pick an address that is likely readable in the current bank
		function logic [15:0] read_candidate();
			int n;
			int r;
			int off;
			if (rom_slots.size() != 0 && $urandom_range(0, 2) == 0) begin
				n = rom_slots.size();
				r = rom_slots[$urandom_range(n > 8 ? n - 8 : 0, n - 1)];
				off = r - bank_base();
				if (off >= 0 && off < int'(BANK_BYTES)) return 16'(16'h4000 + off);
			end
			if (main_addrs.size() != 0) begin
				return 16'(main_addrs[$urandom_range(0, main_addrs.size() - 1)]);
			end
			return 16'($urandom);
		endfunction

		// Apply an accepted input beat and queue the result it owes
		function void note_beat(in_item_t b);
			out_item_t   e;
			logic [7:0]  v;
			logic [15:0] nxt;
			bit          lo_err;
			bit          hi_err;
			e = '0;
			nxt = b.address + 16'd1;
			case (b.mode)
				MODE_RD_BYTE: e.read_data = {8'h00, bus_byte(b.address)};
				MODE_RD_SBYTE: begin
					v = bus_byte(b.address);
					e.read_data = {{8{v[7]}}, v};
				end
				MODE_WR_BYTE: e.error = bus_write(b.address, b.write_data[7:0]);
				MODE_RD_WORD: e.read_data = {bus_byte(nxt), bus_byte(b.address)};
				MODE_WR_WORD: begin
					lo_err = bus_write(b.address, b.write_data[7:0]);
					hi_err = bus_write(nxt, b.write_data[15:8]);
					e.error = lo_err | hi_err;
				end
				MODE_LD_MAIN: store_main(b.address, b.write_data[7:0]);
				MODE_LD_ROM:  store_rom(int'(b.rom_index) % ROM_SIZE, b.write_data[7:0]);
				default: ;
			endcase
			e.ram_enabled = ram_en;
			e.banking_mode = mode_reg;
			e.current_rom_bank = bank_sel;
			if (e.error) ro_hits++;
			mode_hits[b.mode]++;
			beats_in++;
			due_results.push_back(e);
		endfunction

		task flag_mismatch(string what);
			$display("MISMATCH at result %0d: %s", results_seen, what);
			errors++;
		endtask

		// Compare one result beat with the oldest prediction
		task check_beat(out_item_t got);
			out_item_t e;
			results_seen++;
			if (due_results.size() == 0) begin
				flag_mismatch("result beat with nothing outstanding");
				return;
			end
			e = due_results.pop_front();
			if (got.read_data !== e.read_data)
				flag_mismatch($sformatf("read_data %h, want %h", got.read_data, e.read_data));
			if (got.error !== e.error)
				flag_mismatch($sformatf("error %b, want %b", got.error, e.error));
			if (got.ram_enabled !== e.ram_enabled)
				flag_mismatch($sformatf("ram_enabled %b, want %b",
					got.ram_enabled, e.ram_enabled));
			if (got.banking_mode !== e.banking_mode)
				flag_mismatch($sformatf("banking_mode %h, want %h",
					got.banking_mode, e.banking_mode));
			if (got.current_rom_bank !== e.current_rom_bank)
				flag_mismatch($sformatf("current_rom_bank %h, want %h",
					got.current_rom_bank, e.current_rom_bank));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;

	bank_bus_model sb;
	int unsigned   cycles = 0;
	bit            tail_quiet = 1'b0;
	int            sent = 0;

	banked_memory_bus_controller #(
		.ROM_BANKS(ROM_BANKS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// Drain result beats: random stall bursts, one long hold-off, calm stretches
	initial begin : drain
		int burst;
		int hold;
		bit held;
		burst = 0;
		hold = 0;
		held = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) sb.check_beat(out_item);
			if (!held && sb.beats_in >= 300) begin
				held = 1'b1;
				hold = 80;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				out_ready <= 1'b0;
			end else if (!tail_quiet && (cycles / 512) % 3 != 2
					&& $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 9) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one beat, hold it until taken, then maybe idle for a burst
	task automatic send_beat(input in_item_t b);
		in_valid <= 1'b1;
		in_item <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_beat(b);
		sent++;
		if (!tail_quiet && (sent / 128) % 2 == 0 && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic send_fields(input logic [2:0] m, input logic [15:0] a,
			input logic [15:0] d, input logic [19:0] r);
		in_item_t b;
		b.mode = m;
		b.address = a;
		b.write_data = d;
		b.rom_index = r;
		send_beat(b);
	endtask

	// Build a random beat; reads only target bytes that were written
	function automatic in_item_t random_beat();
		in_item_t    b;
		int          pick;
		int          tries;
		logic [15:0] a;
		bit          found;
		b.mode = MODE_UNUSED;
		b.address = 16'($urandom);
		b.write_data = 16'($urandom);
		b.rom_index = 20'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			b.mode = MODE_LD_MAIN;
			if ($urandom_range(0, 3) != 0) b.address[15] = 1'b1;
		end else if (pick < 24) begin
			b.mode = MODE_LD_ROM;
			if ($urandom_range(0, 2) != 0)
				b.rom_index = 20'(sb.bank_base() + $urandom_range(0, BANK_BYTES - 1));
		end else if (pick < 46) begin
			b.mode = $urandom_range(0, 1) ? MODE_WR_WORD : MODE_WR_BYTE;
			case ($urandom_range(0, 9))
				0: begin
					b.address[15:13] = REGION_RAM_EN;
					if ($urandom_range(0, 1)) b.write_data[7:0] = RAM_EN_KEY;
				end
				1: begin
					b.address[15:13] = REGION_BANK;
					if ($urandom_range(0, 5) == 0) b.write_data[7:0] = 8'h00;
				end
				2: b.address[15:13] = REGION_RO;
				3: b.address[15:13] = REGION_MODE;
				default: b.address[15] = 1'b1;
			endcase
		end else if (pick < 97) begin
			case ($urandom_range(0, 2))
				0: b.mode = MODE_RD_BYTE;
				1: b.mode = MODE_RD_SBYTE;
				default: b.mode = MODE_RD_WORD;
			endcase
			found = 1'b0;
			a = '0;
			for (tries = 0; tries < 12 && !found; tries++) begin
				a = sb.read_candidate();
				if (b.mode == MODE_RD_WORD && $urandom_range(0, 1)) a = a - 16'd1;
				found = sb.can_read(a)
					&& (b.mode != MODE_RD_WORD || sb.can_read(a + 16'd1));
			end
			// Fall back to filling the store when nothing readable turns up
			if (found) b.address = a;
			else b.mode = MODE_LD_MAIN;
		end
		return b;
	endfunction

	initial begin : stimulus
		int i;
		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: unused mode, wrapping words, sign bit, bank zero and wrap,
		// latch decode, read-only writes, extremes of every field
		send_fields(MODE_UNUSED,   16'hFFFF, 16'hFFFF, 20'hFFFFF);
		send_fields(MODE_LD_MAIN,  16'h0000, 16'h0080, 20'h00000);
		send_fields(MODE_LD_MAIN,  16'hFFFF, 16'hFF7F, 20'hFFFFF);
		send_fields(MODE_RD_WORD,  16'hFFFF, 16'h0000, 20'h00000);
		send_fields(MODE_RD_SBYTE, 16'h0000, 16'hFFFF, 20'hFFFFF);
		send_fields(MODE_RD_BYTE,  16'hFFFF, 16'h0000, 20'h00000);
		send_fields(MODE_LD_ROM,   16'h0000, 16'h00A5, 20'hFFFFF);
		send_fields(MODE_WR_BYTE,  16'h2000, 16'h0000, 20'h00000);
		send_fields(MODE_WR_BYTE,  16'h3FFF, 16'hFFFF, 20'h00000);
		send_fields(MODE_RD_BYTE,  16'h7FFF, 16'h0000, 20'h00000);
		send_fields(MODE_RD_SBYTE, 16'h7FFF, 16'h0000, 20'h00000);
		send_fields(MODE_WR_BYTE,  16'h0000, 16'h000A, 20'h00000);
		send_fields(MODE_WR_BYTE,  16'h1FFF, 16'h000B, 20'h00000);
		send_fields(MODE_WR_WORD,  16'h1FFF, 16'h0A0A, 20'h00000);
		send_fields(MODE_WR_BYTE,  16'h4000, 16'h0055, 20'h00000);
		send_fields(MODE_WR_WORD,  16'h3FFF, 16'h1234, 20'h00000);
		send_fields(MODE_WR_BYTE,  16'h6000, 16'h00FF, 20'h00000);
		send_fields(MODE_WR_BYTE,  16'h7FFF, 16'h0000, 20'h00000);
		send_fields(MODE_WR_WORD,  16'h7FFF, 16'hBEEF, 20'h00000);
		send_fields(MODE_WR_BYTE,  16'hFFFF, 16'h1234, 20'h00000);
		send_fields(MODE_WR_WORD,  16'hFFFF, 16'hCDAB, 20'h00000);
		send_fields(MODE_LD_ROM,   16'hFFFF, 16'h005A, 20'h00000);
		send_fields(MODE_WR_BYTE,  16'h2000, 16'h0040, 20'h00000);
		send_fields(MODE_RD_BYTE,  16'h4000, 16'h0000, 20'h00000);
		send_fields(MODE_RD_WORD,  16'hFFFF, 16'h0000, 20'h00000);

		// Random traffic, calm at the end
		for (i = 0; i < N_RANDOM; i++) begin
			if (i >= N_RANDOM - QUIET_TAIL) tail_quiet = 1'b1;
			send_beat(random_beat());
		end
		in_valid <= 1'b0;

		// Drain, then watch for stray result beats
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d beats: %0d byte, %0d signed, %0d word reads;",
			sb.beats_in, sb.mode_hits[MODE_RD_BYTE], sb.mode_hits[MODE_RD_SBYTE],
			sb.mode_hits[MODE_RD_WORD]);
		$display("%0d byte, %0d word writes; loads %0d main, %0d rom; %0d unused-mode;",
			sb.mode_hits[MODE_WR_BYTE], sb.mode_hits[MODE_WR_WORD],
			sb.mode_hits[MODE_LD_MAIN], sb.mode_hits[MODE_LD_ROM],
			sb.mode_hits[MODE_UNUSED]);
		$display("%0d read-only hits; %0d results, %0d bad",
			sb.ro_hits, sb.results_seen, sb.errors);
		if (sb.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
